// ===== hw/rtl/paired_lane_combine_pipeline_core_assert.svh =====
// Assertion macros used by the checker file of this block.
// Every macro expands to one labeled concurrent assertion that reports by $error.
`ifndef PAIRED_LANE_COMBINE_PIPELINE_CORE_ASSERT_SVH
`define PAIRED_LANE_COMBINE_PIPELINE_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define PLCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define PLCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define PLCP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/plcp_pkg.sv =====
`timescale 1ns / 1ps

package plcp_pkg;

    // Fixed item geometry.
    localparam int LANES   = 4;
    localparam int LANE_W  = 32;
    localparam int TAG_W   = 8;
    localparam int OP_W    = 3;
    localparam int STAGES  = 3;

    // Request word layout, lowest bit first: op_code, flit_tag, lanes 0 to 3, zero fill.
    localparam int IN_OP_LSB   = 0;
    localparam int IN_TAG_LSB  = IN_OP_LSB + OP_W;
    localparam int IN_LANE_LSB = IN_TAG_LSB + TAG_W;
    localparam int IN_BITS     = IN_LANE_LSB + LANES * LANE_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Result word layout, lowest bit first: out_tag, lanes 0 to 3.
    localparam int OUT_BITS    = TAG_W + LANES * LANE_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;

    // Request kinds carried on the input sideband.
    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef logic [LANE_W-1:0]             lane_t;
    typedef logic [LANES-1:0][LANE_W-1:0]  lanes_t;
    typedef logic [TAG_W-1:0]              tag_t;
    typedef logic [OP_W-1:0]               op_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_AND = 3'd1,
        OP_OR  = 3'd2,
        OP_XOR = 3'd3,
        OP_MIN = 3'd4,
        OP_MAX = 3'd5
    } op_e;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic   is_tick;
        logic   op_known;
        op_t    op;
        tag_t   tag;
        lanes_t lanes;
    } item_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic   accepted;
        logic   out_valid;
        tag_t   tag;
        lanes_t lanes;
    } res_t;

    // True for the opcodes that have a combine rule.
    function automatic logic op_is_known(op_t op);
        logic known;
        unique case (op)
            OP_ADD, OP_AND, OP_OR, OP_XOR, OP_MIN, OP_MAX: known = 1'b1;
            default:                                       known = 1'b0;
        endcase
        return known;
    endfunction

    // Combine one lane of the held operand with one lane of the incoming flit.
    function automatic lane_t combine_lane(op_t op, lane_t a, lane_t b);
        lane_t r;
        unique case (op)
            OP_ADD:  r = a + b;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_MIN:  r = (a < b) ? a : b;
            OP_MAX:  r = (a > b) ? a : b;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/plcp_front.sv =====
`timescale 1ns / 1ps

module plcp_front
    import plcp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    output logic                 item_valid,
    input  logic                 item_ready,
    output item_t                item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    // The stage takes a new request whenever its slot is empty or drains this cycle.
    assign s_axis_tready = !valid_reg || item_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    // Unpack the request and classify its kind and opcode.
    always_comb begin
        item_next          = item_reg;
        item_next.is_tick  = (s_axis_tuser == FUNC_TICK);
        item_next.op       = s_axis_tdata[IN_OP_LSB +: OP_W];
        item_next.op_known = op_is_known(s_axis_tdata[IN_OP_LSB +: OP_W]);
        item_next.tag      = s_axis_tdata[IN_TAG_LSB +: TAG_W];
        item_next.lanes    = s_axis_tdata[IN_LANE_LSB +: LANES * LANE_W];
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/plcp_queue.sv =====
`timescale 1ns / 1ps

module plcp_queue
    import plcp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/plcp_back.sv =====
`timescale 1ns / 1ps

module plcp_back
    import plcp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    // Held operand.
    logic   held_valid_reg;
    logic   held_valid_next;
    op_t    held_op_reg;
    op_t    held_op_next;
    tag_t   held_tag_reg;
    tag_t   held_tag_next;
    lanes_t held_lanes_reg;
    lanes_t held_lanes_next;

    // Three-stage result pipeline.
    logic [STAGES-1:0] stage_valid_reg;
    logic [STAGES-1:0] stage_valid_next;
    lanes_t            stage_lanes_reg [STAGES];
    lanes_t            stage_lanes_next [STAGES];
    tag_t              stage_tag_reg [STAGES];
    tag_t              stage_tag_next [STAGES];

    // Output register.
    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;
    res_t res_next;

    logic   pop;
    logic   pair_ok;
    lanes_t combined;

    // A request is carried out whenever the output register is free or drains now.
    assign item_ready = !res_valid_reg || res_ready;
    assign pop        = item_valid && item_ready;

    // An offer pairs only with a matching operand, an empty entry stage and a known opcode.
    assign pair_ok = (item.op == held_op_reg) && (item.tag == held_tag_reg)
                     && !stage_valid_reg[0] && item.op_known;

    // Lane-wise combine of the held operand with the incoming flit.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            combined[i] = combine_lane(held_op_reg, held_lanes_reg[i], item.lanes[i]);
        end
    end

    // Next state for hold, pipeline and output.
    always_comb begin
        held_valid_next  = held_valid_reg;
        held_op_next     = held_op_reg;
        held_tag_next    = held_tag_reg;
        held_lanes_next  = held_lanes_reg;
        stage_valid_next = stage_valid_reg;
        stage_lanes_next = stage_lanes_reg;
        stage_tag_next   = stage_tag_reg;
        res_valid_next   = res_valid_reg;
        res_next         = res_reg;

        if (pop) begin
            res_valid_next = 1'b1;
            res_next       = '0;
            if (item.is_tick) begin
                // Emit the last stage when it holds a flit, then shift.
                if (stage_valid_reg[STAGES-1]) begin
                    res_next.out_valid = 1'b1;
                    res_next.tag       = stage_tag_reg[STAGES-1];
                    res_next.lanes     = stage_lanes_reg[STAGES-1];
                end
                stage_valid_next = {stage_valid_reg[STAGES-2:0], 1'b0};
                for (int s = 1; s < STAGES; s++) begin
                    stage_lanes_next[s] = stage_lanes_reg[s-1];
                    stage_tag_next[s]   = stage_tag_reg[s-1];
                end
            end else if (!held_valid_reg) begin
                // First offer becomes the held operand.
                held_valid_next = 1'b1;
                held_op_next    = item.op;
                held_tag_next   = item.tag;
                held_lanes_next = item.lanes;
            end else if (pair_ok) begin
                stage_valid_next[0] = 1'b1;
                stage_lanes_next[0] = combined;
                stage_tag_next[0]   = held_tag_reg;
                held_valid_next     = 1'b0;
                res_next.accepted   = 1'b1;
            end
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg  <= 1'b0;
            stage_valid_reg <= '0;
            res_valid_reg   <= 1'b0;
        end else begin
            held_valid_reg  <= held_valid_next;
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_op_reg     <= held_op_next;
        held_tag_reg    <= held_tag_next;
        held_lanes_reg  <= held_lanes_next;
        stage_lanes_reg <= stage_lanes_next;
        stage_tag_reg   <= stage_tag_next;
        res_reg         <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/paired_lane_combine_pipeline_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | tdata                                  | tuser
// s_axis   | in        | op_code, flit_tag, in_lane_0..3        | func (0 offer, 1 tick)
// m_axis   | out       | out_tag, out_lane_0..3                 | accepted, out_valid
//
// Every request yields exactly one result; one request is taken per cycle when m_axis_tready
// stays high. A request passes through the front register, the request queue and the output
// register of the back end, which holds the operand and the three pipeline stages.
// Reset is synchronous on aresetn low and empties the hold, the stages and the queue.
// With m_axis_tready low the output register, then the queue and then the front fill up,
// after which s_axis_tready drops.

module paired_lane_combine_pipeline_core
    import plcp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // op_code[2:0], flit_tag[10:3], in_lane_0..in_lane_3 from bit 11 in 32-bit steps, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_tag[7:0], out_lane_0..out_lane_3 from bit 8 in 32-bit steps
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // accepted[0], out_valid[1]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    logic  fr_valid;
    logic  fr_ready;
    item_t fr_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;
    res_t  res;

    plcp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (fr_valid),
        .item_ready    (fr_ready),
        .item          (fr_item)
    );

    plcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    plcp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    // Pack the result onto the output bus.
    assign m_axis_tdata = OUT_DATA_W'({res.lanes, res.tag});
    assign m_axis_tuser = {res.out_valid, res.accepted};

endmodule

// ===== hw/rtl/plcp_checker.sv =====
`timescale 1ns / 1ps
`include "paired_lane_combine_pipeline_core_assert.svh"

module plcp_checker
    import plcp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // A stalled result keeps its payload and flags.
    `PLCP_ASSERT_NEXT(a_res_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // A result never reports both a pairing and an emitted flit.
    `PLCP_ASSERT_IMPLY(a_flags_excl, aclk, aresetn, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "accepted and out_valid both set")

    // Without an emitted flit the tag and lanes read as zero.
    `PLCP_ASSERT_IMPLY(a_zero_payload, aclk, aresetn, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata == '0, "payload not zero without emitted flit")

    // Reset leaves no result on the bus.
    `PLCP_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_axis_tvalid, "result present after reset")

endmodule

bind paired_lane_combine_pipeline_core plcp_checker u_plcp_checker (.*);
